FILE: rtl/core/ellipsoid_mercator_projection_top_assert.svh
// assertion macros for the mercator projection block
// every macro samples on clk and is disabled while arst_n is low
`ifndef ELLIPSOID_MERCATOR_PROJECTION_TOP_ASSERT_SVH
`define ELLIPSOID_MERCATOR_PROJECTION_TOP_ASSERT_SVH

// same-cycle implication
`define EMP_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("emp assertion failed");

// next-cycle implication
`define EMP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("emp assertion failed");

`endif

FILE: rtl/core/emp_pkg.sv
`default_nettype none
package emp_pkg;

	localparam logic [63:0] ONE_Q56 = 64'd1 << 56;
	localparam logic [63:0] DEC18 = 64'd1000000000000000000;

	// pipeline geometry
	localparam int MUL_LAT = 2;
	localparam int DIV_LAT = 2;
	localparam int CELL_LAT = 3 + DIV_LAT;
	localparam int DIV_STEPS = 56;
	localparam int LN_TERMS = 20;
	localparam int TRIG_TERMS = 12;
	localparam int AT_TERMS = 10;
	localparam int LN_LAT = 2 + DIV_STEPS + MUL_LAT + CELL_LAT * LN_TERMS + 1;

	localparam logic [41:0] EAST_MAX = 42'h1FF_FFFF_FFFF;
	localparam logic [47:0] NORTH_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [63:0] RADIUS = 64'd6378137;

	// per-request data that rides alongside the northing math
	typedef struct packed {
		logic [30:0] lon_mag;
		logic lon_neg;
		logic lat_neg;
		logic pole;
		logic last;
	} side_t;

	// elaboration-time helpers for the fixed constants
	function automatic logic [63:0] f_mulshr(input logic [63:0] a, input logic [63:0] b,
			input int s);
		logic [127:0] full;
		logic [127:0] shr;
		full = 128'(a) * 128'(b) + (128'd1 << (s - 1));
		shr = full >> s;
		return (shr[127:64] != 64'd0) ? '1 : shr[63:0];
	endfunction

	function automatic logic [63:0] f_div56(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		r = n;
		q = 64'd0;
		if (d == 64'd0 || n >= d || d > (64'd1 << 63)) return 64'd0;
		for (int i = 0; i < 56; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 64'd1;
			end
		end
		return q;
	endfunction

	// smallest l with 2^l >= d
	function automatic int f_clog2(input int d);
		int l;
		l = 0;
		for (int i = 0; i < 31; i++) begin
			if ((64'd1 << i) < 64'(d)) l = i + 1;
		end
		return l;
	endfunction

	// low 64 bits of ceil(2^(64+l)/d); the full reciprocal is 2^64 plus this
	function automatic logic [63:0] f_recip_lo(input int d);
		logic [127:0] num;
		logic [127:0] m;
		num = 128'd1 << (64 + f_clog2(d));
		m = (num + 128'(d) - 128'd1) / 128'(d);
		return m[63:0];
	endfunction

	localparam logic [63:0] LN2_Q56 = f_div56(64'd693147180559945309, DEC18);
	localparam logic [63:0] Q_Q56 = f_div56(64'd785398163397448310, DEC18);
	localparam logic [63:0] EQ_Q56 = f_div56(64'd81819190842621486, DEC18);
	localparam logic [63:0] KQ40 = (64'd111319 << 40)
		+ ((f_div56(64'd49079327357, 64'd100000000000) + 64'd32768) >> 16);

	function automatic logic [63:0] f_ln_unit(input logic [63:0] m);
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] sum;
		z = f_div56(m - ONE_Q56, m + ONE_Q56);
		z2 = f_mulshr(z, z, 56);
		p = z;
		sum = z;
		for (int k = 1; k <= 20; k++) begin
			p = f_mulshr(p, z2, 56);
			sum = sum + p / 64'(2 * k + 1);
		end
		return sum << 1;
	endfunction

	function automatic logic [63:0] f_ln_fix(input logic [63:0] v, input int fb);
		int n;
		logic [63:0] m;
		n = 0;
		if (v == 64'd0) return 64'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) n = i;
		end
		m = (n <= 56) ? (v << (56 - n)) : (v >> (n - 56));
		return 64'(n - fb) * LN2_Q56 + f_ln_unit(m);
	endfunction

	localparam logic [63:0] LNQ_Q56 = f_ln_fix(Q_Q56, 56);
	localparam logic [63:0] LN90_Q56 = f_ln_fix(64'd90, 0);

endpackage
`default_nettype wire

FILE: rtl/core/ellipsoid_mercator_projection_top.sv
// throughput: one request per cycle, sustained, while out_stall stays low
// the pipeline depth is mostly set by the 56-cell quotient chain and 20 series cells of the log units
// out_stall freezes the whole pipeline while the output is valid; in_stall follows a stalled, valid output
// reset (arst_n low) clears the valid pipeline and the output valid; payload is not reset
`default_nettype none
module ellipsoid_mercator_projection_top #(
	parameter int ANGLE_FRAC_BITS = 22,
	parameter int METRE_FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [30:0] longitude,
	input logic signed [29:0] latitude,
	input logic last_point,
	output logic out_valid,
	input logic out_stall,
	output logic signed [41:0] easting,
	output logic signed [47:0] northing,
	output logic pole_flag,
	output logic last_out
);
	import emp_pkg::*;

	localparam logic [29:0] POLAR = 30'(90 << ANGLE_FRAC_BITS);
	localparam logic [63:0] LNK = LNQ_Q56 - LN90_Q56 - 64'(ANGLE_FRAC_BITS) * LN2_Q56;
	localparam int H_DEN_LOG = f_clog2(90);
	localparam logic [63:0] H_RECIP = f_recip_lo(90);

	// stage times, counted from the first register
	localparam int T_H = MUL_LAT + DIV_LAT;
	localparam int T_H2 = T_H + MUL_LAT;
	localparam int T_TRIG = T_H2 + CELL_LAT * TRIG_TERMS;
	localparam int T_LNTAN = T_TRIG + LN_LAT + 1;
	localparam int T_S = T_TRIG + 2 * MUL_LAT + 1;
	localparam int T_W2 = T_S + 2 * MUL_LAT;
	localparam int T_EQAT = T_W2 + CELL_LAT * AT_TERMS + MUL_LAT;
	localparam int T_PSI = T_LNTAN + 1;
	localparam int T_OUT = T_PSI + MUL_LAT;
	localparam int H_DLY = T_TRIG - T_H;
	localparam int C_DLY = T_TRIG;
	localparam int E_DLY = T_LNTAN - T_EQAT;

	logic en;
	logic [30:0] lon_u;
	logic [29:0] lat_u;
	side_t side_in;
	side_t side_q [T_OUT + 1];
	logic [29:0] c_s1;
	logic vld_q [T_OUT + 1];
	logic [63:0] t_y, h2_y, sh_y, sh2_y, w_y, w2_y, eqat_y, east_y, north_y;
	logic [63:0] ln_c, ln_s, ln_k;
	logic [63:0] hll_s3, hlh_s3, hhl_s3, hhh_s3, t_s3;
	logic [128:0] h_full;
	logic [128:0] h_shr;
	logic [63:0] h_s4;
	logic [63:0] h_q [H_DLY];
	logic [29:0] c_q [C_DLY];
	logic [63:0] e_q [E_DLY];
	logic [63:0] w_q [2];
	logic [63:0] s_q;
	logic [63:0] tw;
	logic [63:0] ln_tan_q;
	logic [63:0] psi;
	logic [63:0] mag_q;
	logic pneg_q [3];
	logic [63:0] tp [TRIG_TERMS];
	logic [63:0] tx [TRIG_TERMS];
	logic [63:0] tsum [TRIG_TERMS + 1];
	logic [63:0] cp [TRIG_TERMS];
	logic [63:0] csum [TRIG_TERMS + 1];
	logic [63:0] ap [AT_TERMS];
	logic [63:0] ax [AT_TERMS];
	logic [63:0] asum [AT_TERMS + 1];
	logic [41:0] east_sat;
	logic [47:0] north_sat;
	logic north_neg;
	logic out_valid_q;
	logic [41:0] easting_q;
	logic [47:0] northing_q;
	logic pole_flag_q, last_out_q;

	// pipeline advances unless a result is held
	assign en = !(out_valid_q && out_stall);
	assign in_stall = out_valid_q && out_stall;

	// magnitudes and signs
	always_comb begin
		lon_u = $unsigned(longitude);
		lat_u = $unsigned(latitude);
		side_in.lon_neg = lon_u[30];
		side_in.lat_neg = lat_u[29];
		side_in.lon_mag = lon_u[30] ? (~lon_u + 31'd1) : lon_u;
		side_in.pole = 1'b0;
		side_in.last = last_point;
		if (lat_u[29]) begin
			side_in.pole = ((~lat_u + 30'd1) >= POLAR);
		end else begin
			side_in.pole = (lat_u >= POLAR);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= side_in;
			for (int i = 1; i <= T_OUT; i++) side_q[i] <= side_q[i - 1];
			if (side_in.pole) c_s1 <= 30'd0;
			else if (lat_u[29]) c_s1 <= POLAR - (~lat_u + 30'd1);
			else c_s1 <= POLAR - lat_u;
		end
	end

	// valid line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= T_OUT; i++) vld_q[i] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q[0] <= in_valid;
			for (int i = 1; i <= T_OUT; i++) vld_q[i] <= vld_q[i - 1];
			out_valid_q <= vld_q[T_OUT];
		end
	end

	// half colatitude in radians
	emp_mul #(.SHIFT(ANGLE_FRAC_BITS)) u_mul_t (
		.clk(clk), .en(en), .a(64'(c_s1)), .b(Q_Q56), .y(t_y)
	);

	// exact quotient by 90 through the reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			hll_s3 <= 64'(t_y[31:0]) * 64'(H_RECIP[31:0]);
			hlh_s3 <= 64'(t_y[31:0]) * 64'(H_RECIP[63:32]);
			hhl_s3 <= 64'(t_y[63:32]) * 64'(H_RECIP[31:0]);
			hhh_s3 <= 64'(t_y[63:32]) * 64'(H_RECIP[63:32]);
			t_s3 <= t_y;
		end
	end

	always_comb begin
		h_full = {1'b0, t_s3, 64'd0} + {1'b0, hhh_s3, 64'd0}
			+ {33'd0, hlh_s3, 32'd0} + {33'd0, hhl_s3, 32'd0} + {65'd0, hll_s3};
		h_shr = h_full >> (64 + H_DEN_LOG);
	end

	always_ff @(posedge clk) begin
		if (en) h_s4 <= h_shr[63:0];
	end

	emp_mul #(.SHIFT(56)) u_mul_h2 (
		.clk(clk), .en(en), .a(h_s4), .b(h_s4), .y(h2_y)
	);

	// delay lines for h, c and the eccentricity term
	always_ff @(posedge clk) begin
		if (en) begin
			h_q[0] <= h_s4;
			for (int i = 1; i < H_DLY; i++) h_q[i] <= h_q[i - 1];
			c_q[0] <= c_s1;
			for (int i = 1; i < C_DLY; i++) c_q[i] <= c_q[i - 1];
			e_q[0] <= eqat_y;
			for (int i = 1; i < E_DLY; i++) e_q[i] <= e_q[i - 1];
		end
	end

	// sin(h)/h and cos(h) taylor chains
	assign tp[0] = ONE_Q56;
	assign tx[0] = h2_y;
	assign tsum[0] = ONE_Q56;
	assign cp[0] = ONE_Q56;
	assign csum[0] = ONE_Q56;
	for (genvar k = 1; k <= TRIG_TERMS; k++) begin : g_trig
		if (k < TRIG_TERMS) begin : g_mid
			emp_series_cell #(.DEN((2 * k) * (2 * k + 1)), .DIV_P(1'b1),
					.NEG((k % 2) == 1)) u_sin (
				.clk(clk), .en(en),
				.p_in(tp[k - 1]), .x_in(tx[k - 1]), .sum_in(tsum[k - 1]),
				.p_out(tp[k]), .x_out(tx[k]), .sum_out(tsum[k])
			);
			emp_series_cell #(.DEN((2 * k - 1) * (2 * k)), .DIV_P(1'b1),
					.NEG((k % 2) == 1)) u_cos (
				.clk(clk), .en(en),
				.p_in(cp[k - 1]), .x_in(tx[k - 1]), .sum_in(csum[k - 1]),
				.p_out(cp[k]), .x_out(), .sum_out(csum[k])
			);
		end else begin : g_last
			emp_series_cell #(.DEN((2 * k) * (2 * k + 1)), .DIV_P(1'b1),
					.NEG((k % 2) == 1)) u_sin (
				.clk(clk), .en(en),
				.p_in(tp[k - 1]), .x_in(tx[k - 1]), .sum_in(tsum[k - 1]),
				.p_out(), .x_out(), .sum_out(tsum[k])
			);
			emp_series_cell #(.DEN((2 * k - 1) * (2 * k)), .DIV_P(1'b1),
					.NEG((k % 2) == 1)) u_cos (
				.clk(clk), .en(en),
				.p_in(cp[k - 1]), .x_in(tx[k - 1]), .sum_in(csum[k - 1]),
				.p_out(), .x_out(), .sum_out(csum[k])
			);
		end
	end

	// logs of the colatitude (ln h once LNK is added), sin(h)/h and cos(h)
	emp_ln_unit #(.FB_IN(0)) u_ln_c (
		.clk(clk), .en(en), .v(64'(c_q[C_DLY - 1])), .ln(ln_c)
	);
	emp_ln_unit #(.FB_IN(56)) u_ln_s (
		.clk(clk), .en(en), .v(tsum[TRIG_TERMS]), .ln(ln_s)
	);
	emp_ln_unit #(.FB_IN(56)) u_ln_k (
		.clk(clk), .en(en), .v(csum[TRIG_TERMS]), .ln(ln_k)
	);

	always_ff @(posedge clk) begin
		if (en) ln_tan_q <= ln_c + LNK + ln_s - ln_k;
	end

	// sin phi = 1 - 2 sin^2 h
	emp_mul #(.SHIFT(56)) u_mul_sh (
		.clk(clk), .en(en), .a(h_q[H_DLY - 1]), .b(tsum[TRIG_TERMS]), .y(sh_y)
	);
	emp_mul #(.SHIFT(56)) u_mul_sh2 (
		.clk(clk), .en(en), .a(sh_y), .b(sh_y), .y(sh2_y)
	);

	assign tw = {sh2_y[62:0], 1'b0};

	always_ff @(posedge clk) begin
		if (en) s_q <= (tw >= ONE_Q56) ? 64'd0 : ONE_Q56 - tw;
	end

	// atanh(e sin phi) series
	emp_mul #(.SHIFT(56)) u_mul_w (
		.clk(clk), .en(en), .a(EQ_Q56), .b(s_q), .y(w_y)
	);
	emp_mul #(.SHIFT(56)) u_mul_w2 (
		.clk(clk), .en(en), .a(w_y), .b(w_y), .y(w2_y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			w_q[0] <= w_y;
			w_q[1] <= w_q[0];
		end
	end

	assign ap[0] = w_q[1];
	assign ax[0] = w2_y;
	assign asum[0] = w_q[1];
	for (genvar k = 1; k <= AT_TERMS; k++) begin : g_at
		if (k < AT_TERMS) begin : g_mid
			emp_series_cell #(.DEN(2 * k + 1), .DIV_P(1'b0), .NEG(1'b0)) u_cell (
				.clk(clk), .en(en),
				.p_in(ap[k - 1]), .x_in(ax[k - 1]), .sum_in(asum[k - 1]),
				.p_out(ap[k]), .x_out(ax[k]), .sum_out(asum[k])
			);
		end else begin : g_last
			emp_series_cell #(.DEN(2 * k + 1), .DIV_P(1'b0), .NEG(1'b0)) u_cell (
				.clk(clk), .en(en),
				.p_in(ap[k - 1]), .x_in(ax[k - 1]), .sum_in(asum[k - 1]),
				.p_out(), .x_out(), .sum_out(asum[k])
			);
		end
	end

	emp_mul #(.SHIFT(56)) u_mul_eqat (
		.clk(clk), .en(en), .a(EQ_Q56), .b(asum[AT_TERMS]), .y(eqat_y)
	);

	// isometric latitude, sign and magnitude
	assign psi = 64'd0 - ln_tan_q - e_q[E_DLY - 1];

	always_ff @(posedge clk) begin
		if (en) begin
			mag_q <= psi[63] ? (64'd0 - psi) : psi;
			pneg_q[0] <= psi[63];
			pneg_q[1] <= pneg_q[0];
			pneg_q[2] <= pneg_q[1];
		end
	end

	// scale to metres
	emp_mul #(.SHIFT(56 - METRE_FRAC_BITS)) u_mul_north (
		.clk(clk), .en(en), .a(mag_q), .b(RADIUS), .y(north_y)
	);
	emp_mul #(.SHIFT(40 + ANGLE_FRAC_BITS - METRE_FRAC_BITS)) u_mul_east (
		.clk(clk), .en(en), .a(64'(side_q[T_PSI].lon_mag)), .b(KQ40), .y(east_y)
	);

	// saturate and apply signs
	always_comb begin
		east_sat = (east_y > 64'(EAST_MAX)) ? EAST_MAX : east_y[41:0];
		if (side_q[T_OUT].pole) begin
			north_sat = NORTH_MAX;
			north_neg = side_q[T_OUT].lat_neg;
		end else begin
			north_sat = (north_y > 64'(NORTH_MAX)) ? NORTH_MAX : north_y[47:0];
			north_neg = side_q[T_OUT].lat_neg ^ pneg_q[2];
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			easting_q <= side_q[T_OUT].lon_neg ? (42'd0 - east_sat) : east_sat;
			northing_q <= north_neg ? (48'd0 - north_sat) : north_sat;
			pole_flag_q <= side_q[T_OUT].pole;
			last_out_q <= side_q[T_OUT].last;
		end
	end

	assign out_valid = out_valid_q;
	assign easting = $signed(easting_q);
	assign northing = $signed(northing_q);
	assign pole_flag = pole_flag_q;
	assign last_out = last_out_q;
endmodule
`default_nettype wire

FILE: rtl/core/emp_mul.sv
`default_nettype none
module emp_mul #(
	parameter int SHIFT = 56
) (
	input logic clk,
	input logic en,
	input logic [63:0] a,
	input logic [63:0] b,
	output logic [63:0] y
);
	logic [63:0] ll_s1, lh_s1, hl_s1, hh_s1;
	logic [63:0] y_s2;
	logic [127:0] full;
	logic [127:0] shr;

	// four 32x32 partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= 64'(a[31:0]) * 64'(b[31:0]);
			lh_s1 <= 64'(a[31:0]) * 64'(b[63:32]);
			hl_s1 <= 64'(a[63:32]) * 64'(b[31:0]);
			hh_s1 <= 64'(a[63:32]) * 64'(b[63:32]);
		end
	end

	// combine, round half up, shift, saturate to all ones
	always_comb begin
		full = {hh_s1, 64'd0} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
			+ {64'd0, ll_s1} + (128'd1 << (SHIFT - 1));
		shr = full >> SHIFT;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			y_s2 <= (shr[127:64] != 64'd0) ? '1 : shr[63:0];
		end
	end

	assign y = y_s2;
endmodule
`default_nettype wire

FILE: rtl/core/emp_div_cell.sv
`default_nettype none
module emp_div_cell (
	input logic clk,
	input logic en,
	input logic [63:0] r_in,
	input logic [63:0] d_in,
	input logic [63:0] q_in,
	output logic [63:0] r_out,
	output logic [63:0] d_out,
	output logic [63:0] q_out
);
	logic [63:0] r2;
	logic [63:0] r_s1, d_s1, q_s1;

	assign r2 = {r_in[62:0], 1'b0};

	// one restoring quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_in;
			if (r2 >= d_in) begin
				r_s1 <= r2 - d_in;
				q_s1 <= {q_in[62:0], 1'b1};
			end else begin
				r_s1 <= r2;
				q_s1 <= {q_in[62:0], 1'b0};
			end
		end
	end

	assign r_out = r_s1;
	assign d_out = d_s1;
	assign q_out = q_s1;
endmodule
`default_nettype wire

FILE: rtl/core/emp_series_cell.sv
`default_nettype none
module emp_series_cell #(
	parameter int DEN = 3,
	parameter bit DIV_P = 1'b0,
	parameter bit NEG = 1'b0
) (
	input logic clk,
	input logic en,
	input logic [63:0] p_in,
	input logic [63:0] x_in,
	input logic [63:0] sum_in,
	output logic [63:0] p_out,
	output logic [63:0] x_out,
	output logic [63:0] sum_out
);
	import emp_pkg::*;

	localparam int DEN_LOG = f_clog2(DEN);
	localparam logic [63:0] RECIP_LO = f_recip_lo(DEN);

	logic [63:0] prod;
	logic [63:0] ll_s3, lh_s3, hl_s3, hh_s3, prod_s3, prod_s4;
	logic [128:0] quo_full;
	logic [128:0] quo_shr;
	logic [63:0] term_s4;
	logic [63:0] x_s1, x_s2, x_s3, x_s4, sum_s1, sum_s2, sum_s3, sum_s4;
	logic [63:0] p_s5, x_s5, sum_s5;

	// next power of the term
	emp_mul #(.SHIFT(56)) u_mul (
		.clk(clk),
		.en(en),
		.a(p_in),
		.b(x_in),
		.y(prod)
	);

	// exact quotient by the constant: product with its reciprocal
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s3 <= 64'(prod[31:0]) * 64'(RECIP_LO[31:0]);
			lh_s3 <= 64'(prod[31:0]) * 64'(RECIP_LO[63:32]);
			hl_s3 <= 64'(prod[63:32]) * 64'(RECIP_LO[31:0]);
			hh_s3 <= 64'(prod[63:32]) * 64'(RECIP_LO[63:32]);
			prod_s3 <= prod;
		end
	end

	always_comb begin
		quo_full = {1'b0, prod_s3, 64'd0} + {1'b0, hh_s3, 64'd0}
			+ {33'd0, lh_s3, 32'd0} + {33'd0, hl_s3, 32'd0} + {65'd0, ll_s3};
		quo_shr = quo_full >> (64 + DEN_LOG);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			term_s4 <= quo_shr[63:0];
			prod_s4 <= prod_s3;
		end
	end

	// carry multiplier and partial sum past the product
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_in;
			x_s2 <= x_s1;
			x_s3 <= x_s2;
			x_s4 <= x_s3;
			sum_s1 <= sum_in;
			sum_s2 <= sum_s1;
			sum_s3 <= sum_s2;
			sum_s4 <= sum_s3;
			x_s5 <= x_s4;
			p_s5 <= DIV_P ? term_s4 : prod_s4;
			sum_s5 <= NEG ? (sum_s4 - term_s4) : (sum_s4 + term_s4);
		end
	end

	assign p_out = p_s5;
	assign x_out = x_s5;
	assign sum_out = sum_s5;
endmodule
`default_nettype wire

FILE: rtl/core/emp_ln_unit.sv
`default_nettype none
module emp_ln_unit #(
	parameter int FB_IN = 56
) (
	input logic clk,
	input logic en,
	input logic [63:0] v,
	output logic [63:0] ln
);
	import emp_pkg::*;

	localparam int SIDE_LEN = LN_LAT - 1;

	logic [5:0] nb;
	logic [63:0] m_s1;
	logic [63:0] r_s2, d_s2;
	logic [6:0] side_q [SIDE_LEN];
	logic [63:0] dr [DIV_STEPS + 1];
	logic [63:0] dd [DIV_STEPS + 1];
	logic [63:0] dq [DIV_STEPS + 1];
	logic [63:0] z2;
	logic [63:0] z_q [2];
	logic [63:0] sp [LN_TERMS];
	logic [63:0] sx [LN_TERMS];
	logic [63:0] ss [LN_TERMS + 1];
	logic [63:0] off;
	logic [63:0] ln_q;

	// leading one position
	always_comb begin
		nb = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) nb = 6'(i);
		end
	end

	// normalize mantissa into [1,2)
	always_ff @(posedge clk) begin
		if (en) begin
			if (nb <= 6'd56) m_s1 <= v << (6'd56 - nb);
			else m_s1 <= v >> (nb - 6'd56);
			r_s2 <= m_s1 - ONE_Q56;
			d_s2 <= m_s1 + ONE_Q56;
		end
	end

	// exponent and zero mark ride along
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= {nb, (v == 64'd0)};
			for (int i = 1; i < SIDE_LEN; i++) side_q[i] <= side_q[i - 1];
		end
	end

	// z = (m-1)/(m+1), one quotient bit per cell
	assign dr[0] = r_s2;
	assign dd[0] = d_s2;
	assign dq[0] = 64'd0;
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		emp_div_cell u_cell (
			.clk(clk),
			.en(en),
			.r_in(dr[k]),
			.d_in(dd[k]),
			.q_in(dq[k]),
			.r_out(dr[k + 1]),
			.d_out(dd[k + 1]),
			.q_out(dq[k + 1])
		);
	end

	emp_mul #(.SHIFT(56)) u_sq (
		.clk(clk),
		.en(en),
		.a(dq[DIV_STEPS]),
		.b(dq[DIV_STEPS]),
		.y(z2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			z_q[0] <= dq[DIV_STEPS];
			z_q[1] <= z_q[0];
		end
	end

	// atanh series on z
	assign sp[0] = z_q[1];
	assign sx[0] = z2;
	assign ss[0] = z_q[1];
	for (genvar k = 1; k <= LN_TERMS; k++) begin : g_term
		if (k < LN_TERMS) begin : g_mid
			emp_series_cell #(.DEN(2 * k + 1), .DIV_P(1'b0), .NEG(1'b0)) u_cell (
				.clk(clk), .en(en),
				.p_in(sp[k - 1]), .x_in(sx[k - 1]), .sum_in(ss[k - 1]),
				.p_out(sp[k]), .x_out(sx[k]), .sum_out(ss[k])
			);
		end else begin : g_last
			emp_series_cell #(.DEN(2 * k + 1), .DIV_P(1'b0), .NEG(1'b0)) u_cell (
				.clk(clk), .en(en),
				.p_in(sp[k - 1]), .x_in(sx[k - 1]), .sum_in(ss[k - 1]),
				.p_out(), .x_out(), .sum_out(ss[k])
			);
		end
	end

	// exponent times ln2 plus twice the series
	assign off = ({58'd0, side_q[SIDE_LEN - 1][6:1]} - 64'(FB_IN)) * LN2_Q56;

	always_ff @(posedge clk) begin
		if (en) begin
			ln_q <= side_q[SIDE_LEN - 1][0] ? 64'd0 : off + {ss[LN_TERMS][62:0], 1'b0};
		end
	end

	assign ln = ln_q;
endmodule
`default_nettype wire

FILE: rtl/core/emp_checker.sv
`default_nettype none
`include "ellipsoid_mercator_projection_top_assert.svh"
module emp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic signed [30:0] longitude,
	input logic signed [29:0] latitude,
	input logic last_point,
	input logic out_valid,
	input logic out_stall,
	input logic signed [41:0] easting,
	input logic signed [47:0] northing,
	input logic pole_flag,
	input logic last_out
);
	// a held result keeps its northing
	`EMP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(northing))

	// a stalled result backs up into the input side
	`EMP_ASSERT_IMPLY(a_back_press, out_valid && out_stall, in_stall)

	// pole results carry the saturated northing
	`EMP_ASSERT_IMPLY(a_pole_sat, out_valid && pole_flag,
		northing == 48'sh7FFF_FFFF_FFFF || northing == 48'sh8000_0000_0001)

	// easting saturates symmetrically
	`EMP_ASSERT_IMPLY(a_east_sym, out_valid, easting != 42'sh200_0000_0000)
endmodule

bind ellipsoid_mercator_projection_top emp_checker u_emp_checker (.*);
`default_nettype wire
